/* sv/bqd_pkg.sv */
// ----------------------------------------------------------------------------
// Biquad filter package
// Sequencer states, register indexes and datapath control codes shared by the
// biquad section.
// ----------------------------------------------------------------------------
package bqd_pkg;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5,
      ST_M6,
      ST_M7,
      ST_M8,
      ST_M9,
      ST_M10,
      ST_FIN
   } state_type;

   // Alignment of a partial product within the accumulator
   typedef enum logic [1:0] {
      SH_ZERO,
      SH_HALF,
      SH_FRAC,
      SH_FRAC_HALF
   } shift_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_INIT_A,
      ACC_INIT_B,
      ACC_INIT_C,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

endpackage

/* sv/biquad_df2t_filter_unit.sv */
// ----------------------------------------------------------------------------
// Biquad filter unit, transposed direct form II
// One shared coefficient-by-half-word multiplier forms ten partial products per
// sample, one in each of ST_M0 to ST_M9; the result is registered in ST_FIN.
// A new sample is taken only in ST_IDLE; ST_FIN waits for the output register.
// Reset restores bypass coefficients (b0 = 1.0) and clears both delays.
// ----------------------------------------------------------------------------
module biquad_df2t_filter_unit #(
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]   rsp_sample_out,
   input  logic                            csr_write,
   input  logic [bqd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEF_FRAC_BITS+1:0]       csr_data
);

   localparam int CF  = COEF_FRAC_BITS;
   localparam int CB  = COEF_FRAC_BITS + 2;
   localparam int ACC = SAMPLE_BITS + COEF_FRAC_BITS + 2;
   localparam int H   = (ACC + 1) / 2;
   localparam int CH  = H + 1;
   localparam int PB  = CB + CH;
   localparam int W   = ACC + CF + 4;
   localparam int QB  = W - CF;
   localparam int YB  = ACC + 1 - CF;

   bqd_pkg::state_type   state_ff, state_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CB-1:0]        coef_b0_ff, coef_b0_in;
   logic [CB-1:0]        coef_b1_ff, coef_b1_in;
   logic [CB-1:0]        coef_b2_ff, coef_b2_in;
   logic [CB-1:0]        coef_a1_ff, coef_a1_in;
   logic [CB-1:0]        coef_a2_ff, coef_a2_in;
   logic [ACC-1:0]       delay_one_ff, delay_one_in;
   logic [ACC-1:0]       delay_two_ff, delay_two_in;
   logic [ACC-1:0]       x_ff, x_in;
   logic [ACC-1:0]       r_ff, r_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [W-1:0]         prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;

   bqd_pkg::csr_index_type mul_sel;
   bqd_pkg::shift_type     mul_shift;
   bqd_pkg::acc_op_type    acc_op;
   logic                   mul_src_r;
   logic                   mul_hi;
   logic [ACC-1:0]         mul_opnd;
   logic signed [CB-1:0]   mul_coef;
   logic signed [CH-1:0]   mul_chunk;
   logic signed [PB-1:0]   mul_p;
   logic [W-1:0]           mul_w;

   logic [QB-1:0]          acc_q;
   logic [ACC-1:0]         acc_sat;
   logic [ACC:0]           y_sum;
   logic [YB-1:0]          y_q;
   logic [SAMPLE_BITS-1:0] y_sat;
   logic                   accept;
   logic                   out_free;
   logic [W-1:0]           init_a;
   logic [W-1:0]           init_b;
   logic [W-1:0]           init_c;

   // ---------------------------------------------------------------------
   // Shared multiplier: coefficient times one half of a wide operand
   // ---------------------------------------------------------------------
   always_comb begin
      mul_opnd = mul_src_r ? r_ff : x_ff;
      if (mul_hi) begin
         mul_chunk = {{(CH-ACC+H){mul_opnd[ACC-1]}}, mul_opnd[ACC-1:H]};
      end else begin
         mul_chunk = {1'b0, mul_opnd[H-1:0]};
      end
      unique case (mul_sel)
         bqd_pkg::CSR_B0: mul_coef = coef_b0_ff;
         bqd_pkg::CSR_B1: mul_coef = coef_b1_ff;
         bqd_pkg::CSR_B2: mul_coef = coef_b2_ff;
         bqd_pkg::CSR_A1: mul_coef = coef_a1_ff;
         bqd_pkg::CSR_A2: mul_coef = coef_a2_ff;
         default:         mul_coef = coef_b0_ff;
      endcase
      mul_p = mul_coef * mul_chunk;
      mul_w = {{(W-PB){mul_p[PB-1]}}, mul_p};
      case (mul_shift)
         bqd_pkg::SH_ZERO:      prod_in = mul_w;
         bqd_pkg::SH_HALF:      prod_in = mul_w << H;
         bqd_pkg::SH_FRAC:      prod_in = mul_w << CF;
         bqd_pkg::SH_FRAC_HALF: prod_in = mul_w << (CF + H);
         default:               prod_in = mul_w;
      endcase
   end

   // ---------------------------------------------------------------------
   // Saturation of the accumulator and output rounding
   // ---------------------------------------------------------------------
   always_comb begin
      acc_q = acc_ff[W-1:CF];
      if ((&acc_q[QB-1:ACC-1]) || !(|acc_q[QB-1:ACC-1])) begin
         acc_sat = acc_q[ACC-1:0];
      end else if (acc_q[QB-1]) begin
         acc_sat = {1'b1, {(ACC-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(ACC-1){1'b1}}};
      end

      // round half up: add one half, drop the fraction
      y_sum = {r_ff[ACC-1], r_ff} + {{(ACC+1-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
      y_q   = y_sum[ACC:CF];
      if ((&y_q[YB-1:SAMPLE_BITS-1]) || !(|y_q[YB-1:SAMPLE_BITS-1])) begin
         y_sat = y_q[SAMPLE_BITS-1:0];
      end else if (y_q[YB-1]) begin
         y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   // Accumulator start values; init_b and init_c carry one half minus one in
   // the low fraction bits so the subtracted feedback product rounds to nearest
   assign init_a = {{4{delay_one_ff[ACC-1]}}, delay_one_ff, {CF{1'b0}}};
   assign init_b = {{4{delay_two_ff[ACC-1]}}, delay_two_ff, 1'b0, {(CF-1){1'b1}}};
   assign init_c = {{(W-CF+1){1'b0}}, {(CF-1){1'b1}}};

   assign accept   = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer and register next values
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_sample_in = out_sample_ff;
      delay_one_in  = delay_one_ff;
      delay_two_in  = delay_two_ff;
      x_in          = x_ff;
      r_in          = r_ff;
      mul_sel       = bqd_pkg::CSR_B0;
      mul_src_r     = 1'b0;
      mul_hi        = 1'b0;
      mul_shift     = bqd_pkg::SH_ZERO;
      acc_op        = bqd_pkg::ACC_HOLD;

      coef_b0_in = coef_b0_ff;
      coef_b1_in = coef_b1_ff;
      coef_b2_in = coef_b2_ff;
      coef_a1_in = coef_a1_ff;
      coef_a2_in = coef_a2_ff;
      if (csr_write) begin
         unique case (csr_index)
            bqd_pkg::CSR_B0: coef_b0_in = csr_data;
            bqd_pkg::CSR_B1: coef_b1_in = csr_data;
            bqd_pkg::CSR_B2: coef_b2_in = csr_data;
            bqd_pkg::CSR_A1: coef_a1_in = csr_data;
            bqd_pkg::CSR_A2: coef_a2_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         bqd_pkg::ST_IDLE: begin
            if (accept) begin
               x_in     = {{(ACC-SAMPLE_BITS){req_sample_in[SAMPLE_BITS-1]}}, req_sample_in};
               acc_op   = bqd_pkg::ACC_INIT_A;
               state_in = bqd_pkg::ST_M0;
            end
         end
         bqd_pkg::ST_M0: begin
            mul_sel   = bqd_pkg::CSR_B0;
            mul_shift = bqd_pkg::SH_FRAC;
            state_in  = bqd_pkg::ST_M1;
         end
         bqd_pkg::ST_M1: begin
            mul_sel   = bqd_pkg::CSR_B0;
            mul_hi    = 1'b1;
            mul_shift = bqd_pkg::SH_FRAC_HALF;
            acc_op    = bqd_pkg::ACC_ADD;
            state_in  = bqd_pkg::ST_M2;
         end
         bqd_pkg::ST_M2: begin
            mul_sel   = bqd_pkg::CSR_B1;
            mul_shift = bqd_pkg::SH_FRAC;
            acc_op    = bqd_pkg::ACC_ADD;
            state_in  = bqd_pkg::ST_M3;
         end
         bqd_pkg::ST_M3: begin
            // full-precision sum is complete: capture it and start delay one
            r_in      = acc_sat;
            mul_sel   = bqd_pkg::CSR_B1;
            mul_hi    = 1'b1;
            mul_shift = bqd_pkg::SH_FRAC_HALF;
            acc_op    = bqd_pkg::ACC_INIT_B;
            state_in  = bqd_pkg::ST_M4;
         end
         bqd_pkg::ST_M4: begin
            mul_sel   = bqd_pkg::CSR_A1;
            mul_src_r = 1'b1;
            mul_shift = bqd_pkg::SH_ZERO;
            acc_op    = bqd_pkg::ACC_ADD;
            state_in  = bqd_pkg::ST_M5;
         end
         bqd_pkg::ST_M5: begin
            mul_sel   = bqd_pkg::CSR_A1;
            mul_src_r = 1'b1;
            mul_hi    = 1'b1;
            mul_shift = bqd_pkg::SH_HALF;
            acc_op    = bqd_pkg::ACC_SUB;
            state_in  = bqd_pkg::ST_M6;
         end
         bqd_pkg::ST_M6: begin
            mul_sel   = bqd_pkg::CSR_B2;
            mul_shift = bqd_pkg::SH_FRAC;
            acc_op    = bqd_pkg::ACC_SUB;
            state_in  = bqd_pkg::ST_M7;
         end
         bqd_pkg::ST_M7: begin
            delay_one_in = acc_sat;
            mul_sel      = bqd_pkg::CSR_B2;
            mul_hi       = 1'b1;
            mul_shift    = bqd_pkg::SH_FRAC_HALF;
            acc_op       = bqd_pkg::ACC_INIT_C;
            state_in     = bqd_pkg::ST_M8;
         end
         bqd_pkg::ST_M8: begin
            mul_sel   = bqd_pkg::CSR_A2;
            mul_src_r = 1'b1;
            mul_shift = bqd_pkg::SH_ZERO;
            acc_op    = bqd_pkg::ACC_ADD;
            state_in  = bqd_pkg::ST_M9;
         end
         bqd_pkg::ST_M9: begin
            mul_sel   = bqd_pkg::CSR_A2;
            mul_src_r = 1'b1;
            mul_hi    = 1'b1;
            mul_shift = bqd_pkg::SH_HALF;
            acc_op    = bqd_pkg::ACC_SUB;
            state_in  = bqd_pkg::ST_M10;
         end
         bqd_pkg::ST_M10: begin
            acc_op   = bqd_pkg::ACC_SUB;
            state_in = bqd_pkg::ST_FIN;
         end
         bqd_pkg::ST_FIN: begin
            delay_two_in = acc_sat;
            // hold here until the output register is free
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_sample_in = y_sat;
               state_in      = bqd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bqd_pkg::ST_IDLE;
         end
      endcase

      case (acc_op)
         bqd_pkg::ACC_INIT_A: acc_in = init_a;
         bqd_pkg::ACC_INIT_B: acc_in = init_b + prod_ff;
         bqd_pkg::ACC_INIT_C: acc_in = init_c + prod_ff;
         bqd_pkg::ACC_ADD:    acc_in = acc_ff + prod_ff;
         bqd_pkg::ACC_SUB:    acc_in = acc_ff - prod_ff;
         default:             acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bqd_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         coef_b0_ff   <= {2'b01, {CF{1'b0}}};
         coef_b1_ff   <= '0;
         coef_b2_ff   <= '0;
         coef_a1_ff   <= '0;
         coef_a2_ff   <= '0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         coef_b0_ff   <= coef_b0_in;
         coef_b1_ff   <= coef_b1_in;
         coef_b2_ff   <= coef_b2_in;
         coef_a1_ff   <= coef_a1_in;
         coef_a2_ff   <= coef_a2_in;
         delay_one_ff <= delay_one_in;
         delay_two_ff <= delay_two_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      r_ff          <= r_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      out_sample_ff <= out_sample_in;
   end

   assign req_stall      = (state_ff != bqd_pkg::ST_IDLE);
   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == bqd_pkg::ST_M0)
      else $error("accepted transaction did not start the multiply sequence");

   a_delay_one_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != bqd_pkg::ST_M7 |=> $stable(delay_one_ff))
      else $error("delay one changed outside its update step");

   a_delay_two_step: assert property (@(posedge clock) disable iff (reset)
      state_ff != bqd_pkg::ST_FIN |=> $stable(delay_two_ff))
      else $error("delay two changed outside its update step");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == bqd_pkg::ST_FIN && rsp_valid && rsp_stall |=> state_ff == bqd_pkg::ST_FIN)
      else $error("sequence left final step while output register was occupied");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == bqd_pkg::ST_FIN)
      else $error("result raised outside final step");

endmodule

/* sim/bqd_scoreboard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad section scoreboard
// Bit-true transposed direct form II predictor with its own copy of the taps
// and delays. Each accepted input sample queues one expected output sample,
// and each output transaction is checked in order against that queue.
// ----------------------------------------------------------------------------
package bqd_tb_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int FRAC_W       = 22;
   localparam int COEF_W       = FRAC_W + 2;
   localparam int ACC_W        = SAMPLE_W + FRAC_W + 2;
   localparam int REPORT_LIMIT = 10;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   // Room for a coefficient times a full accumulator with no wrap
   typedef logic signed [2*ACC_W-1:0]  wide_type;

   class biquad_scoreboard;
      coef_type   tap_b0, tap_b1, tap_b2, tap_a1, tap_a2;
      acc_type    z1, z2;
      sample_type expected_out[$];
      int         failures;
      int         outputs_seen;

      function new();
         tap_b0       = coef_type'(1 << FRAC_W);
         tap_b1       = '0;
         tap_b2       = '0;
         tap_a1       = '0;
         tap_a2       = '0;
         z1           = '0;
         z2           = '0;
         failures     = 0;
         outputs_seen = 0;
      endfunction

      function wide_type clamp(wide_type v, int bits);
         wide_type hi, lo;
         hi = (wide_type'(1) <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // Round to nearest, ties upward: add half an LSB, then floor
      function wide_type round_q(wide_type v);
         return (v + (wide_type'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      endfunction

      function void set_tap(logic [bqd_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [COEF_W-1:0] val);
         case (idx)
            bqd_pkg::CSR_B0: tap_b0 = coef_type'(val);
            bqd_pkg::CSR_B1: tap_b1 = coef_type'(val);
            bqd_pkg::CSR_B2: tap_b2 = coef_type'(val);
            bqd_pkg::CSR_A1: tap_a1 = coef_type'(val);
            bqd_pkg::CSR_A2: tap_a2 = coef_type'(val);
            default: ;
         endcase
      endfunction

      // Feedback takes the unrounded sum, not the output sample
      function sample_type filter_sample(sample_type x);
         wide_type xw, sum, fb_one, fb_two;
         xw     = x;
         sum    = clamp(wide_type'(tap_b0) * xw + wide_type'(z1), ACC_W);
         fb_one = round_q(wide_type'(tap_a1) * sum);
         fb_two = round_q(wide_type'(tap_a2) * sum);
         z1     = acc_type'(clamp(wide_type'(tap_b1) * xw - fb_one + wide_type'(z2), ACC_W));
         z2     = acc_type'(clamp(wide_type'(tap_b2) * xw - fb_two, ACC_W));
         return sample_type'(clamp(round_q(sum), SAMPLE_W));
      endfunction

      function void report(string what);
         failures++;
         if (failures <= REPORT_LIMIT) $display("%t  %s", $time, what);
      endfunction

      function void note_sample(sample_type x);
         expected_out.push_back(filter_sample(x));
      endfunction

      function void check_output(sample_type got);
         sample_type want;
         outputs_seen++;
         if (expected_out.size() == 0) begin
            report($sformatf("output %0d: got %0d with nothing expected", outputs_seen, got));
            return;
         end
         want = expected_out.pop_front();
         if (got !== want)
            report($sformatf("output %0d: expected %0d, got %0d", outputs_seen, want, got));
      endfunction

      function int outstanding();
         return expected_out.size();
      endfunction

      function void finish_check();
         if (expected_out.size() != 0)
            report($sformatf("%0d expected outputs never arrived", expected_out.size()));
      endfunction
   endclass

endpackage

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad filter unit testbench
// Drives samples and coefficient writes into the transposed direct form II
// section with random gaps and output stalls, and checks every output sample
// against a bit-true predictor: directed bypass, tie-rounding and saturation
// runs first, then bursts of random samples under varied tap settings.
// ----------------------------------------------------------------------------
module testbench;

   typedef logic [bqd_pkg::CSR_INDEX_BITS-1:0] csr_idx_type;

   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 30;
   localparam int RANDOM_ITEMS  = 875;
   localparam int RUN_LIMIT_NS  = 2_000_000;
   localparam int CSR_INDEX_TOP = (1 << bqd_pkg::CSR_INDEX_BITS) - 1;
   localparam int Q_ONE         = 1 << bqd_tb_pkg::FRAC_W;
   localparam int Q_MAX         = (1 << (bqd_tb_pkg::COEF_W - 1)) - 1;
   localparam int Q_MIN         = -(1 << (bqd_tb_pkg::COEF_W - 1));
   localparam bqd_tb_pkg::sample_type SAMPLE_MAX =
      bqd_tb_pkg::sample_type'((1 << (bqd_tb_pkg::SAMPLE_W - 1)) - 1);
   localparam bqd_tb_pkg::sample_type SAMPLE_MIN =
      bqd_tb_pkg::sample_type'(-(1 << (bqd_tb_pkg::SAMPLE_W - 1)));

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic                            req_stall;
   bqd_tb_pkg::sample_type          req_sample_in = '0;
   logic                            rsp_valid;
   logic                            rsp_stall     = 1'b0;
   bqd_tb_pkg::sample_type          rsp_sample_out;
   logic                            csr_write     = 1'b0;
   csr_idx_type                     csr_index     = bqd_pkg::CSR_B0;
   logic [bqd_tb_pkg::COEF_W-1:0]   csr_data      = '0;

   bqd_tb_pkg::biquad_scoreboard sb = new();
   int stall_left = 0;
   int free_left  = 0;

   biquad_df2t_filter_unit #(
      .SAMPLE_BITS    (bqd_tb_pkg::SAMPLE_W),
      .COEF_FRAC_BITS (bqd_tb_pkg::FRAC_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #2 clock = ~clock;

   function automatic int rand_span(int lim);
      return int'($urandom_range(2 * lim)) - lim;
   endfunction

   function automatic int extreme_tap();
      case ($urandom_range(0, 4))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 0;
         3: return Q_ONE;
         default: return -Q_ONE;
      endcase
   endfunction

   function automatic int pick_gap(bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Leave the write enable high; the caller drops it after the last write
   task automatic write_csr(input csr_idx_type idx,
                            input logic [bqd_tb_pkg::COEF_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      sb.set_tap(idx, val);
   endtask

   task automatic program_taps(input int b0, input int b1, input int b2,
                               input int a1, input int a2);
      write_csr(bqd_pkg::CSR_B0, bqd_tb_pkg::coef_type'(b0));
      write_csr(bqd_pkg::CSR_B1, bqd_tb_pkg::coef_type'(b1));
      write_csr(bqd_pkg::CSR_B2, bqd_tb_pkg::coef_type'(b2));
      write_csr(bqd_pkg::CSR_A1, bqd_tb_pkg::coef_type'(a1));
      write_csr(bqd_pkg::CSR_A2, bqd_tb_pkg::coef_type'(a2));
      // an unmapped index must leave every tap alone
      write_csr(csr_idx_type'($urandom_range(CSR_INDEX_TOP, bqd_pkg::CSR_A2 + 1)),
                bqd_tb_pkg::coef_type'($urandom));
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Valid stays high when gap is zero so back-to-back transactions follow
   task automatic send_sample(input bqd_tb_pkg::sample_type x, input int gap);
      req_valid     <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(x);
      if (gap > 0) begin
         req_valid     <= 1'b0;
         req_sample_in <= bqd_tb_pkg::sample_type'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_outputs();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_probes(input bqd_tb_pkg::sample_type list[$]);
      foreach (list[i]) send_sample(list[i], pick_gap(1'b0));
      wait_for_outputs();
   endtask

   // Output side: check each transaction, and stall in runs of random length
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_output(rsp_sample_out);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
         free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(0, 6);
         stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 50)
                                                   : $urandom_range(0, 3);
      end
   end

   initial begin
      bqd_tb_pkg::sample_type probes[$];
      bqd_tb_pkg::sample_type x;
      int      sent;
      int      burst_len;
      int      pause_at;
      int      gap;
      int      a2;
      bit      small_mode;
      bit      steady;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset taps pass samples straight through
      probes = '{SAMPLE_MAX, SAMPLE_MIN, 0, 1, -1, 12345};
      run_probes(probes);

      // half gain puts odd samples on a rounding tie
      program_taps(Q_ONE / 2, 0, 0, 0, 0);
      probes = '{1, -1, 3, -3, SAMPLE_MAX, SAMPLE_MIN};
      run_probes(probes);

      // extreme taps drive the sum and both delays into saturation
      program_taps(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN);
      probes = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                 SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
      run_probes(probes);

      program_taps(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX);
      probes = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN};
      run_probes(probes);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1: program_taps($urandom, $urandom, $urandom, $urandom, $urandom);
            2: program_taps(extreme_tap(), extreme_tap(), extreme_tap(),
                            extreme_tap(), extreme_tap());
            default: begin
               // poles kept inside the stability triangle
               a2 = rand_span(Q_ONE * 9 / 10);
               program_taps(rand_span(Q_ONE), rand_span(Q_ONE), rand_span(Q_ONE),
                            rand_span((Q_ONE + a2) * 19 / 20), a2);
            end
         endcase
         burst_len  = $urandom_range(40, 110);
         small_mode = ($urandom_range(0, 3) == 0);
         steady     = ($urandom_range(0, 3) == 0);
         pause_at   = (sent == 0 || $urandom_range(0, 3) == 0)
                      ? $urandom_range(5, burst_len - 5) : -1;
         for (int i = 0; i < burst_len; i++) begin
            if ($urandom_range(0, 99) < 8) begin
               case ($urandom_range(0, 3))
                  0: x = SAMPLE_MAX;
                  1: x = SAMPLE_MIN;
                  2: x = '0;
                  default: x = '1;
               endcase
            end else if (small_mode) begin
               x = bqd_tb_pkg::sample_type'(rand_span(2000));
            end else begin
               x = bqd_tb_pkg::sample_type'($urandom);
            end
            gap = (i == pause_at) ? 1 : pick_gap(steady);
            send_sample(x, gap);
            // hold off mid-burst until the filter has emptied
            if (i == pause_at) wait_for_outputs();
         end
         sent += burst_len;
         wait_for_outputs();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      sb.finish_check();
      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout after %0d ns", RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
